// ===== design/tfsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_pkg
// Shared types, codes and helpers for the three-finger swipe recognizer.
// ----------------------------------------------------------------------------
package tfsr_pkg;

  // Gesture geometry
  localparam int FINGERS    = 3;
  localparam int COORD_BITS = 16;
  localparam int THR_W      = 16;
  localparam int SUM_W      = COORD_BITS + $clog2(FINGERS + 1);
  localparam int LIM_W      = THR_W + $clog2(FINGERS + 1);
  localparam int CMP_W      = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;

  localparam logic [2:0]       COUNT_MAX  = 3'd7;
  localparam logic [THR_W-1:0] THR_RESET  = 16'd320;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [0:0] REG_MOVE_THRESHOLD = 1'b0;

  // Event kinds
  localparam logic [2:0] OP_DOWN   = 3'd0;
  localparam logic [2:0] OP_MOTION = 3'd1;
  localparam logic [2:0] OP_UP     = 3'd2;
  localparam logic [2:0] OP_FRAME  = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;

  // Result status
  localparam logic [2:0] ST_IGNORE = 3'd0;
  localparam logic [2:0] ST_BEGIN  = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_CANCEL = 3'd4;

  // Directions
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_LEFT  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;
  localparam logic [2:0] DIR_DOWN  = 3'd4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [FINGERS-1:0]  pts_t;
  typedef logic [SUM_W-1:0]      sum_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } evt_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] recent_direction;
    logic [2:0] overall_direction;
  } res_t;

  // Coordinate sum over all finger slots
  function automatic sum_t sum_pts(input pts_t v);
    sum_t s;
    s = '0;
    for (int i = 0; i < FINGERS; i++) begin
      s = s + SUM_W'(v[i]);
    end
    return s;
  endfunction

endpackage

// ===== design/tfsr_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_cfg
// APB register block holding the move threshold.
// ----------------------------------------------------------------------------
module tfsr_cfg import tfsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [THR_W-1:0]   move_threshold
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2:2] == REG_MOVE_THRESHOLD);

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && hit) begin
      move_threshold <= pwdata[THR_W-1:0];
    end
  end

  // Read back
  assign prdata = hit ? PDATA_W'(move_threshold) : '0;

endmodule

// ===== design/tfsr_dir.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_dir
// Classifies the shift between two coordinate-sum pairs as a direction.
// ----------------------------------------------------------------------------
module tfsr_dir import tfsr_pkg::*; (
  input  sum_t             a_x,
  input  sum_t             a_y,
  input  sum_t             b_x,
  input  sum_t             b_y,
  input  logic [LIM_W-1:0] limit,
  output logic [2:0]       dir
);

  logic [SUM_W:0]   dx, dy;
  logic [SUM_W-1:0] mx, my;
  logic [CMP_W-1:0] total;
  logic             dx_pos, dy_pos;

  // Signed differences and magnitudes
  assign dx = {1'b0, b_x} - {1'b0, a_x};
  assign dy = {1'b0, b_y} - {1'b0, a_y};
  assign mx = dx[SUM_W] ? SUM_W'(~dx + 1'b1) : dx[SUM_W-1:0];
  assign my = dy[SUM_W] ? SUM_W'(~dy + 1'b1) : dy[SUM_W-1:0];
  assign dx_pos = !dx[SUM_W] && (dx != '0);
  assign dy_pos = !dy[SUM_W] && (dy != '0);
  assign total  = CMP_W'(mx) + CMP_W'(my);

  // Manhattan length against the limit, then dominant axis
  always_comb begin
    if (total < CMP_W'(limit)) begin
      dir = DIR_NONE;
    end else if (mx > my) begin
      dir = dx_pos ? DIR_RIGHT : DIR_LEFT;
    end else begin
      dir = dy_pos ? DIR_DOWN : DIR_UP;
    end
  end

endmodule

// ===== design/tfsr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_core
// Gesture state: finger count, flags, point sets, and the per-event update.
// ----------------------------------------------------------------------------
module tfsr_core import tfsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  evt_t             evt,
  input  logic [THR_W-1:0] move_threshold,
  output res_t             res
);

  logic [2:0] finger_count, finger_count_next;
  logic       cancelled_flag, cancelled_flag_next;
  logic       started_flag, started_flag_next;
  logic [2:0] direction_reg, direction_reg_next;
  pts_t       start_x, start_y, ref_x, ref_y, cur_x, cur_y;
  pts_t       start_x_next, start_y_next, ref_x_next, ref_y_next;
  pts_t       cur_x_next, cur_y_next;

  logic [LIM_W-1:0] limit;
  logic [2:0]       cnt_inc, cnt_dec, frame_dir, overall_dir;
  logic             slot_ok, clear_after;
  logic [2:0]       status;
  coord_t           px, py;

  assign limit   = LIM_W'(move_threshold) * LIM_W'(FINGERS);
  assign cnt_inc = (finger_count != COUNT_MAX) ? finger_count + 3'd1 : finger_count;
  assign cnt_dec = (finger_count != 3'd0) ? finger_count - 3'd1 : finger_count;
  assign slot_ok = (32'(evt.slot) < 32'(FINGERS));
  assign px      = evt.pos_x[COORD_BITS-1:0];
  assign py      = evt.pos_y[COORD_BITS-1:0];

  // Frame shift: reference points to current points
  tfsr_dir u_frame_dir (
    .a_x   (sum_pts(ref_x)),
    .a_y   (sum_pts(ref_y)),
    .b_x   (sum_pts(cur_x)),
    .b_y   (sum_pts(cur_y)),
    .limit (limit),
    .dir   (frame_dir)
  );

  // Overall shift: start points to current points, after this event
  tfsr_dir u_overall_dir (
    .a_x   (sum_pts(start_x_next)),
    .a_y   (sum_pts(start_y_next)),
    .b_x   (sum_pts(cur_x_next)),
    .b_y   (sum_pts(cur_y_next)),
    .limit (limit),
    .dir   (overall_dir)
  );

  // Event handling
  always_comb begin
    finger_count_next   = finger_count;
    cancelled_flag_next = cancelled_flag;
    started_flag_next   = started_flag;
    direction_reg_next  = direction_reg;
    start_x_next        = start_x;
    start_y_next        = start_y;
    ref_x_next          = ref_x;
    ref_y_next          = ref_y;
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    status              = ST_IGNORE;
    clear_after         = 1'b0;

    case (evt.op)
      OP_DOWN: begin
        finger_count_next = cnt_inc;
        if (!cancelled_flag) begin
          if ((32'(cnt_inc) <= 32'(FINGERS)) && slot_ok) begin
            for (int i = 0; i < FINGERS; i++) begin
              if (32'(evt.slot) == i) begin
                start_x_next[i] = px;
                start_y_next[i] = py;
              end
            end
          end
          if (32'(cnt_inc) == 32'(FINGERS)) begin
            started_flag_next = 1'b1;
            ref_x_next        = start_x_next;
            ref_y_next        = start_y_next;
            cur_x_next        = start_x_next;
            cur_y_next        = start_y_next;
            status            = ST_BEGIN;
          end else if (32'(cnt_inc) > 32'(FINGERS)) begin
            cancelled_flag_next = 1'b1;
            status              = ST_CANCEL;
          end
        end
      end
      OP_MOTION: begin
        if (!cancelled_flag && started_flag && slot_ok) begin
          for (int i = 0; i < FINGERS; i++) begin
            if (32'(evt.slot) == i) begin
              cur_x_next[i] = px;
              cur_y_next[i] = py;
            end
          end
        end
      end
      OP_UP: begin
        finger_count_next = cnt_dec;
        if (cnt_dec == 3'd0) begin
          if (!cancelled_flag && started_flag && (direction_reg != DIR_NONE)) begin
            status = ST_FINISH;
          end
          clear_after = 1'b1;
        end
      end
      OP_FRAME: begin
        if (!cancelled_flag && started_flag && (frame_dir != DIR_NONE)) begin
          ref_x_next         = cur_x;
          ref_y_next         = cur_y;
          direction_reg_next = frame_dir;
          status             = ST_UPDATE;
        end
      end
      OP_CANCEL: begin
        cancelled_flag_next = 1'b1;
        status              = ST_CANCEL;
      end
      default: begin
      end
    endcase
  end

  // Result reflects state before the end-of-gesture clear
  assign res.status            = status;
  assign res.recent_direction  = direction_reg_next;
  assign res.overall_direction = started_flag_next ? overall_dir : DIR_NONE;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      finger_count   <= 3'd0;
      cancelled_flag <= 1'b0;
      started_flag   <= 1'b0;
      direction_reg  <= DIR_NONE;
      start_x        <= '0;
      start_y        <= '0;
      ref_x          <= '0;
      ref_y          <= '0;
      cur_x          <= '0;
      cur_y          <= '0;
    end else if (step) begin
      finger_count <= finger_count_next;
      if (clear_after) begin
        cancelled_flag <= 1'b0;
        started_flag   <= 1'b0;
        direction_reg  <= DIR_NONE;
        start_x        <= '0;
        start_y        <= '0;
        ref_x          <= '0;
        ref_y          <= '0;
        cur_x          <= '0;
        cur_y          <= '0;
      end else begin
        cancelled_flag <= cancelled_flag_next;
        started_flag   <= started_flag_next;
        direction_reg  <= direction_reg_next;
        start_x        <= start_x_next;
        start_y        <= start_y_next;
        ref_x          <= ref_x_next;
        ref_y          <= ref_y_next;
        cur_x          <= cur_x_next;
        cur_y          <= cur_y_next;
      end
    end
  end

endmodule

// ===== design/three_finger_swipe_recognizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_finger_swipe_recognizer_unit
// Touch-event gesture recognizer for three-finger swipes.
// ----------------------------------------------------------------------------
// Each touch event word produces exactly one result word. An event is taken
// into an input register and processed combinationally by the gesture state
// logic as it moves into the output register, which sets res_valid. The block
// sustains one event per clock while res_ready does not hold a result in the
// output register. The input register and the output register are separate
// stages, so a new event can still enter an empty input register while a
// finished result waits for res_ready. The user must write the move threshold
// over the APB port only while no event is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module three_finger_swipe_recognizer_unit import tfsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // event channel
  input  logic               evt_valid,
  output logic               evt_ready,
  input  evt_t               evt,
  // result channel
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic             in_full;
  evt_t             in_word;
  logic             advance;
  res_t             step_res;
  logic [THR_W-1:0] move_threshold;

  tfsr_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .move_threshold (move_threshold)
  );

  // Word moves from input register to output register
  assign advance   = in_full && (!res_valid || res_ready);
  assign evt_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (evt_ready) begin
      in_full <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      in_word <= evt;
    end
  end

  tfsr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .evt            (in_word),
    .move_threshold (move_threshold),
    .res            (step_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

endmodule

// ===== tb/three_finger_swipe_recognizer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_finger_swipe_recognizer_unit_tb
// Self-checking bench for the three-finger swipe recognizer.
// ----------------------------------------------------------------------------
// A short table of touch events walks through the corner cases with hand-typed
// results. Random gestures follow: three downs, rounds of motion and frame
// words sized against the move threshold, then the lifts. Finger pile-ups and
// raw noise are mixed in. A gesture tracker inside the bench predicts each
// random result word, and the threshold is rewritten over APB between phases,
// with the sender and receiver idling in one of four patterns per phase.
// ----------------------------------------------------------------------------
module three_finger_swipe_recognizer_unit_tb;
  import tfsr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_EVENTS = 95;

  logic               clk;
  logic               rst = 1'b1;
  logic               evt_valid = 1'b0;
  logic               evt_ready;
  evt_t               evt = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  res_t               res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  three_finger_swipe_recognizer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Gesture tracker state
  logic [THR_W-1:0] thr_now;
  logic [2:0]       touch_count;
  logic             gesture_cancelled;
  logic             gesture_started;
  logic [2:0]       swipe_dir;
  pts_t             start_x, start_y, anchor_x, anchor_y, now_x, now_y;

  res_t expected_results[$];

  // Bookkeeping
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int events_sent = 0;
  int shaped_events = 0;
  bit noise_mode = 1'b0;
  int cycle_count = 0;
  int n_begin = 0, n_update = 0, n_finish = 0, n_cancel = 0, n_ignore = 0;

  typedef struct packed {
    evt_t e;
    logic typed;
    res_t r;
  } row_t;

  row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tracker
  // ---------------------------------------------------------------------------
  function automatic longint coord_total(input pts_t v);
    longint s;
    s = 0;
    for (int i = 0; i < FINGERS; i++) s += longint'(v[i]);
    return s;
  endfunction

  // Direction of the centroid shift, compared on coordinate sums
  function automatic logic [2:0] shift_heading(input pts_t fx, fy, tx, ty);
    longint dx, dy, mx, my;
    dx = coord_total(tx) - coord_total(fx);
    dy = coord_total(ty) - coord_total(fy);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    if (mx + my < longint'(FINGERS) * longint'(thr_now)) return DIR_NONE;
    if (mx > my) return (dx > 0) ? DIR_RIGHT : DIR_LEFT;
    return (dy > 0) ? DIR_DOWN : DIR_UP;
  endfunction

  task automatic clear_gesture();
    gesture_cancelled = 1'b0;
    gesture_started   = 1'b0;
    swipe_dir         = DIR_NONE;
    start_x  = '0;
    start_y  = '0;
    anchor_x = '0;
    anchor_y = '0;
    now_x    = '0;
    now_y    = '0;
  endtask

  task automatic track_touch(input evt_t e, output res_t r);
    logic [2:0] st;
    logic       wipe;
    logic [2:0] heading;
    st   = ST_IGNORE;
    wipe = 1'b0;
    case (e.op)
      OP_DOWN: begin
        if (touch_count != COUNT_MAX) touch_count++;
        if (!gesture_cancelled) begin
          if (touch_count <= FINGERS && e.slot < FINGERS) begin
            start_x[e.slot] = e.pos_x;
            start_y[e.slot] = e.pos_y;
          end
          if (touch_count == FINGERS) begin
            gesture_started = 1'b1;
            anchor_x = start_x;
            anchor_y = start_y;
            now_x    = start_x;
            now_y    = start_y;
            st = ST_BEGIN;
          end else if (touch_count > FINGERS) begin
            gesture_cancelled = 1'b1;
            st = ST_CANCEL;
          end
        end
      end
      OP_MOTION: begin
        if (!gesture_cancelled && gesture_started && e.slot < FINGERS) begin
          now_x[e.slot] = e.pos_x;
          now_y[e.slot] = e.pos_y;
        end
      end
      OP_UP: begin
        if (touch_count != 0) touch_count--;
        if (touch_count == 0) begin
          if (!gesture_cancelled && gesture_started && swipe_dir != DIR_NONE)
            st = ST_FINISH;
          wipe = 1'b1;
        end
      end
      OP_FRAME: begin
        if (!gesture_cancelled && gesture_started) begin
          heading = shift_heading(anchor_x, anchor_y, now_x, now_y);
          if (heading != DIR_NONE) begin
            anchor_x  = now_x;
            anchor_y  = now_y;
            swipe_dir = heading;
            st = ST_UPDATE;
          end
        end
      end
      OP_CANCEL: begin
        gesture_cancelled = 1'b1;
        st = ST_CANCEL;
      end
      default: ;
    endcase
    r.status            = st;
    r.recent_direction  = swipe_dir;
    r.overall_direction = gesture_started ?
                          shift_heading(start_x, start_y, now_x, now_y) : DIR_NONE;
    if (wipe) clear_gesture();
  endtask

  // ---------------------------------------------------------------------------
  // Event sender: drive at falling edge, accept at rising edge
  // ---------------------------------------------------------------------------
  function automatic evt_t make_evt(input logic [2:0] op, input logic [2:0] slot,
                                    input logic [15:0] x, input logic [15:0] y);
    evt_t e;
    e.op    = op;
    e.slot  = slot;
    e.pos_x = x;
    e.pos_y = y;
    return e;
  endfunction

  task automatic send_event(input evt_t e, input logic typed, input res_t typed_res);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      evt_valid = 1'b0;
      @(negedge clk);
    end
    evt       = e;
    evt_valid = 1'b1;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
    track_touch(e, predicted);
    expected_results.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  task automatic put(input logic [2:0] op, input logic [2:0] slot,
                     input int x, input int y);
    send_event(make_evt(op, slot, 16'(x), 16'(y)), 1'b0, '0);
    if (!noise_mode) shaped_events++;
  endtask

  task automatic row(input logic [2:0] op, input logic [2:0] slot,
                     input logic [15:0] x, input logic [15:0] y,
                     input logic [2:0] st, input logic [2:0] rd, input logic [2:0] od);
    directed_rows.push_back({make_evt(op, slot, x, y), 1'b1, st, rd, od});
  endtask

  function automatic int clamp16(input int v);
    return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
  endfunction

  function automatic logic [2:0] any_slot();
    return 3'($urandom_range(7));
  endfunction

  // Lift every finger; a frame now and then between lifts
  task automatic lift_all();
    while (touch_count != 0) begin
      if ($urandom_range(3) == 0) put(OP_FRAME, any_slot(), $urandom, $urandom);
      put(OP_UP, any_slot(), $urandom, $urandom);
    end
  endtask

  // Well-formed swipe with random content
  task automatic run_gesture();
    int         px [3];
    int         py [3];
    logic [2:0] slots [3];
    logic [2:0] tmp;
    int         j, span, dxs, dys, rounds, disturb;
    bit         swipe;
    lift_all();
    slots[0] = 3'd0;
    slots[1] = 3'd1;
    slots[2] = 3'd2;
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    if ($urandom_range(7) == 0) slots[$urandom_range(2)] = 3'($urandom_range(7, 3));
    for (int i = 0; i < 3; i++) begin
      px[i] = $urandom_range(65535);
      py[i] = $urandom_range(65535);
      put(OP_DOWN, slots[i], px[i], py[i]);
    end
    span   = 2 * int'(thr_now) + 8;
    rounds = $urandom_range(6, 1);
    repeat (rounds) begin
      swipe = ($urandom_range(3) != 0);
      dxs = int'($urandom_range(2 * span)) - span;
      dys = int'($urandom_range(2 * span)) - span;
      if (swipe && $urandom_range(1)) dys = dys / 8;
      else if (swipe) dxs = dxs / 8;
      for (int i = 0; i < 3; i++) begin
        if (swipe || $urandom_range(1)) begin
          px[i] = clamp16(px[i] + dxs + int'($urandom_range(8)) - 4);
          py[i] = clamp16(py[i] + dys + int'($urandom_range(8)) - 4);
          put(OP_MOTION, slots[i], px[i], py[i]);
        end
      end
      disturb = $urandom_range(24);
      case (disturb)
        0: put(OP_CANCEL, any_slot(), $urandom, $urandom);
        1: put(OP_DOWN, any_slot(), $urandom, $urandom);
        2: put(OP_MOTION, 3'($urandom_range(7, 3)), $urandom, $urandom);
        default: ;
      endcase
      put(OP_FRAME, any_slot(), $urandom, $urandom);
    end
    lift_all();
  endtask

  // Too many fingers: count saturates and downs land while cancelled
  task automatic run_pileup();
    repeat ($urandom_range(10, 8)) put(OP_DOWN, any_slot(), $urandom, $urandom);
    repeat ($urandom_range(3)) put(OP_FRAME, any_slot(), $urandom, $urandom);
    lift_all();
  endtask

  task automatic run_noise();
    noise_mode = 1'b1;
    repeat ($urandom_range(15, 5))
      put(3'($urandom_range(7)), any_slot(), $urandom, $urandom);
    noise_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // APB access
  // ---------------------------------------------------------------------------
  task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'(4 * REG_MOVE_THRESHOLD);
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_threshold();
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd !== PDATA_W'(thr_now)) begin
      $display("%0t: threshold readback mismatch: expected %0d, got %0d",
               $time, thr_now, rd);
      mismatch_count++;
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b1, PDATA_W'(value), rd);
    thr_now = value;
    check_threshold();
  endtask

  // Block idle: all results back, then let the pipeline settle
  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      case (res.status)
        ST_BEGIN:  n_begin++;
        ST_UPDATE: n_update++;
        ST_FINISH: n_finish++;
        ST_CANCEL: n_cancel++;
        default:   n_ignore++;
      endcase
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: status=%0d recent=%0d overall=%0d",
                 $time, res.status, res.recent_direction, res.overall_direction);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (res.status !== want.status ||
            res.recent_direction !== want.recent_direction ||
            res.overall_direction !== want.overall_direction) begin
          $display("%0t: mismatch: expected status=%0d recent=%0d overall=%0d,",
                   $time, want.status, want.recent_direction, want.overall_direction,
                   " got status=%0d recent=%0d overall=%0d",
                   res.status, res.recent_direction, res.overall_direction);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                target;
    int                pick;
    logic [THR_W-1:0]  thr_pick;
    thr_now     = THR_RESET;
    touch_count = '0;
    clear_gesture();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset value of the threshold
    check_threshold();

    // Directed: threshold 320, so a summed shift of 960 is needed
    row(OP_FRAME,  3'd0, 16'h0000, 16'h0000, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_MOTION, 3'd0, 16'hFFFF, 16'hFFFF, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(3'd7,      3'd7, 16'hFFFF, 16'hFFFF, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_UP,     3'd0, 16'h0000, 16'h0000, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_DOWN,   3'd0, 16'h0000, 16'h0000, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_DOWN,   3'd1, 16'h0000, 16'h0000, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_DOWN,   3'd2, 16'h0000, 16'h0000, ST_BEGIN,  DIR_NONE,  DIR_NONE);
    row(OP_MOTION, 3'd0, 16'hFFFF, 16'h0000, ST_IGNORE, DIR_NONE,  DIR_RIGHT);
    // slot out of range stores nothing
    row(OP_MOTION, 3'd6, 16'hFFFF, 16'hFFFF, ST_IGNORE, DIR_NONE,  DIR_RIGHT);
    row(OP_FRAME,  3'd0, 16'h0000, 16'h0000, ST_UPDATE, DIR_RIGHT, DIR_RIGHT);
    row(OP_MOTION, 3'd1, 16'hFFFF, 16'hFFFF, ST_IGNORE, DIR_RIGHT, DIR_RIGHT);
    // equal magnitudes fall to the vertical axis
    row(OP_MOTION, 3'd2, 16'h0000, 16'hFFFF, ST_IGNORE, DIR_RIGHT, DIR_DOWN);
    row(OP_FRAME,  3'd0, 16'h0000, 16'h0000, ST_UPDATE, DIR_DOWN,  DIR_DOWN);
    row(OP_MOTION, 3'd0, 16'h0000, 16'h0000, ST_IGNORE, DIR_DOWN,  DIR_DOWN);
    row(OP_FRAME,  3'd0, 16'h0000, 16'h0000, ST_UPDATE, DIR_LEFT,  DIR_DOWN);
    row(OP_UP,     3'd0, 16'h0000, 16'h0000, ST_IGNORE, DIR_LEFT,  DIR_DOWN);
    row(OP_UP,     3'd1, 16'h0000, 16'h0000, ST_IGNORE, DIR_LEFT,  DIR_DOWN);
    row(OP_UP,     3'd2, 16'h0000, 16'h0000, ST_FINISH, DIR_LEFT,  DIR_DOWN);
    // up with no fingers left: count holds at zero
    row(OP_UP,     3'd2, 16'hFFFF, 16'hFFFF, ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_DOWN,   3'd0, 16'd100,  16'd200,  ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_DOWN,   3'd1, 16'd300,  16'd400,  ST_IGNORE, DIR_NONE,  DIR_NONE);
    row(OP_DOWN,   3'd2, 16'hFFFF, 16'hFFFF, ST_BEGIN,  DIR_NONE,  DIR_NONE);
    // fourth finger cancels
    row(OP_DOWN,   3'd3, 16'hFFFF, 16'hFFFF, ST_CANCEL, DIR_NONE,  DIR_NONE);
    row(OP_CANCEL, 3'd0, 16'h0000, 16'h0000, ST_CANCEL, DIR_NONE,  DIR_NONE);

    foreach (directed_rows[i])
      send_event(directed_rows[i].e, directed_rows[i].typed, directed_rows[i].r);
    @(negedge clk);
    evt_valid = 1'b0;

    // Random phases, each with its own threshold and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       thr_pick = 16'd0;
        1:       thr_pick = 16'hFFFF;
        2:       thr_pick = 16'd1;
        3:       thr_pick = 16'($urandom_range(2000, 1));
        4:       thr_pick = THR_RESET;
        5:       thr_pick = 16'($urandom);
        6:       thr_pick = 16'($urandom_range(600, 50));
        default: thr_pick = 16'($urandom_range(400));
      endcase
      write_threshold(thr_pick);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 50; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 50; end
        default: begin send_idle_pct = 23; recv_idle_pct = 23; end
      endcase
      target = shaped_events + PHASE_EVENTS;
      while (shaped_events < target) begin
        pick = $urandom_range(9);
        if (pick < 7) run_gesture();
        else if (pick == 7) run_pileup();
        else run_noise();
      end
      @(negedge clk);
      evt_valid = 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d event words across %0d threshold settings and four idling patterns.",
             events_sent, PHASES + 1);
    $display("Results: %0d begun, %0d updates, %0d finished, %0d cancelled, %0d ignored.",
             n_begin, n_update, n_finish, n_cancel, n_ignore);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== three_finger_swipe_recognizer_unit.f =====
design/tfsr_pkg.sv
design/tfsr_cfg.sv
design/tfsr_dir.sv
design/tfsr_core.sv
design/three_finger_swipe_recognizer_unit.sv
tb/three_finger_swipe_recognizer_unit_tb.sv
